// ===== hw/rtl/pn_pkg.sv =====
// ----------------------------------------------------------------------------
// pn_pkg: shared constants and types for the path normaliser
// Buffer and stack sizes, derived widths, character codes, command and
// status codes.
// ----------------------------------------------------------------------------
package pn_pkg;

  // Sizes of the two stores
  localparam int PATH_MAX     = 256;
  localparam int MAX_SEGMENTS = 128;

  // Derived widths
  localparam int BUF_AW  = $clog2(PATH_MAX);
  localparam int LEN_W   = BUF_AW + 1;
  localparam int STK_AW  = $clog2(MAX_SEGMENTS);
  localparam int DEPTH_W = STK_AW + 1;
  localparam int SEG_W   = 9;
  localparam int NEED_W  = ((LEN_W > SEG_W) ? LEN_W : SEG_W) + 1;

  typedef logic [7:0] byte_t;
  typedef logic [1:0] status_t;
  typedef logic       cmd_t;

  // Character codes
  localparam byte_t CH_NUL   = 8'h00;
  localparam byte_t CH_DOT   = 8'h2E;
  localparam byte_t CH_SLASH = 8'h2F;

  // Commands
  localparam cmd_t CMD_FEED = 1'b0;
  localparam cmd_t CMD_READ = 1'b1;

  // Status codes
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_INVALID = 2'd1;
  localparam status_t ST_NOSPACE = 2'd2;

  // Register reset value
  localparam byte_t NAME_LEN_RESET = 8'd255;

endpackage

// ===== hw/rtl/pn_in_if.sv =====
// ----------------------------------------------------------------------------
// pn_in_if: request channel of the path normaliser
// Carries one command item: feed a path byte or read a buffer byte.
// ----------------------------------------------------------------------------
interface pn_in_if;
  import pn_pkg::*;

  logic  valid;
  logic  ready;
  cmd_t  command;
  byte_t char_in;
  byte_t read_index;

  modport source (output valid, output command, output char_in, output read_index,
                  input ready);
  modport sink   (input valid, input command, input char_in, input read_index,
                  output ready);
endinterface

// ===== hw/rtl/pn_out_if.sv =====
// ----------------------------------------------------------------------------
// pn_out_if: result channel of the path normaliser
// Carries one result item per accepted request item.
// ----------------------------------------------------------------------------
interface pn_out_if;
  import pn_pkg::*;

  logic    valid;
  logic    ready;
  logic    done_res;
  status_t status;
  byte_t   path_length;
  byte_t   byte_out;

  modport source (output valid, output done_res, output status, output path_length,
                  output byte_out, input ready);
  modport sink   (input valid, input done_res, input status, input path_length,
                  input byte_out, output ready);
endinterface

// ===== hw/rtl/path_normalizer.sv =====
// ----------------------------------------------------------------------------
// path_normalizer: streaming canonicaliser for absolute paths
// Takes a path one byte per item, builds its canonical form in a buffer RAM
// and keeps segment start lengths on a stack RAM.
// ----------------------------------------------------------------------------
// The block accepts one item per clock cycle and returns its result item in the
// cycle after acceptance; a stalled result holds the request side only for as
// long as the output register stays full. Feed items write at most one byte
// into the buffer RAM per cycle: the separator of the next segment is written
// when the previous segment is kept. A ".." segment restores the length from
// the stack top, which the stack RAM reads continuously at depth - 1; after a
// push or pop it is renewed via the depth and read registers before any "..".
// Read items return the buffer byte through the registered read port of the
// buffer RAM. Neither RAM is cleared after reset, so the block is ready at once.
module path_normalizer (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_en,
  input  pn_pkg::byte_t      cfg_write_data,
  pn_in_if.sink              req,
  pn_out_if.source           rsp
);
  import pn_pkg::*;

  // Segment classification
  localparam logic [1:0] DOT_NONE  = 2'd0;
  localparam logic [1:0] DOT_ONE   = 2'd1;
  localparam logic [1:0] DOT_TWO   = 2'd2;
  localparam logic [1:0] DOT_OTHER = 2'd3;

  // Scalar state
  byte_t              max_name;
  logic [DEPTH_W-1:0] depth, depth_next;
  logic [LEN_W-1:0]   out_len, out_len_next;
  logic [SEG_W-1:0]   seg_len, seg_len_next;
  logic [LEN_W-1:0]   seg_begin, seg_begin_next;
  logic [1:0]         dot_pat, dot_pat_next;
  logic               in_path, in_path_next;
  status_t            status, status_next;
  logic               done_next;

  // Output register
  logic    rsp_valid;
  logic    done_q;
  status_t status_q;
  byte_t   len_q;
  logic    hit_q;

  // RAM ports
  logic              buf_we;
  logic [BUF_AW-1:0] buf_waddr;
  byte_t             buf_wdata;
  logic              buf_re;
  byte_t             buf_rdata;
  logic              stk_we;
  logic [STK_AW-1:0] stk_waddr;
  logic [LEN_W-1:0]  stk_wdata;
  logic [LEN_W-1:0]  stk_top;

  logic accept;
  logic is_feed;
  logic read_hit;

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign is_feed   = req.command == CMD_FEED;
  assign buf_re    = accept && !is_feed;
  assign read_hit  = !is_feed && (NEED_W'(req.read_index) < NEED_W'(out_len));

  pn_ram #(.WIDTH(8), .DEPTH(PATH_MAX)) u_buf_ram (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (buf_wdata),
    .re    (buf_re),
    .raddr (BUF_AW'(req.read_index)),
    .rdata (buf_rdata)
  );

  // Stack top is read back continuously
  pn_ram #(.WIDTH(LEN_W), .DEPTH(MAX_SEGMENTS)) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (1'b1),
    .raddr (STK_AW'(depth - DEPTH_W'(1))),
    .rdata (stk_top)
  );

  // Work out the next state for one feed item
  always_comb begin
    logic [SEG_W-1:0]  sl_inc;
    logic [LEN_W-1:0]  sb_b;
    logic [LEN_W-1:0]  ol_b;
    logic [1:0]        dp_b;
    logic              sep;
    logic [NEED_W-1:0] need;
    logic              do_end;

    depth_next     = depth;
    out_len_next   = out_len;
    seg_len_next   = seg_len;
    seg_begin_next = seg_begin;
    dot_pat_next   = dot_pat;
    in_path_next   = in_path;
    status_next    = status;
    done_next      = 1'b0;
    buf_we         = 1'b0;
    buf_waddr      = out_len[BUF_AW-1:0];
    buf_wdata      = CH_SLASH;
    stk_we         = 1'b0;
    stk_waddr      = depth[STK_AW-1:0];
    stk_wdata      = seg_begin;
    sl_inc         = seg_len + SEG_W'(1);
    sb_b           = seg_begin;
    ol_b           = out_len;
    dp_b           = DOT_OTHER;
    sep            = seg_begin > LEN_W'(1);
    need           = NEED_W'(seg_begin) + NEED_W'(sep) + NEED_W'(seg_len);
    do_end         = 1'b0;

    if (accept && is_feed) begin
      if (!in_path) begin
        // First byte of a path: start afresh
        status_next    = ST_OK;
        depth_next     = '0;
        seg_len_next   = '0;
        seg_begin_next = '0;
        dot_pat_next   = DOT_NONE;
        out_len_next   = '0;
        if (req.char_in == CH_NUL || req.char_in == CH_SLASH) begin
          buf_we       = 1'b1;
          buf_waddr    = '0;
          out_len_next = LEN_W'(1);
          done_next    = req.char_in == CH_NUL;
          in_path_next = req.char_in != CH_NUL;
        end else begin
          status_next  = ST_INVALID;
          in_path_next = 1'b1;
        end
      end else if (req.char_in == CH_NUL) begin
        do_end       = 1'b1;
        seg_len_next = '0;
        dot_pat_next = DOT_NONE;
        in_path_next = 1'b0;
        done_next    = 1'b1;
      end else if (status == ST_OK) begin
        if (req.char_in == CH_SLASH) begin
          do_end = 1'b1;
        end else begin
          // Byte within a segment; the separator is already in place
          if (seg_len == '0) begin
            sb_b = out_len;
            ol_b = out_len + LEN_W'(out_len > LEN_W'(1) &&
                                    out_len < LEN_W'(PATH_MAX - 1));
            dp_b = (req.char_in == CH_DOT) ? DOT_ONE : DOT_OTHER;
          end else begin
            dp_b = (dot_pat == DOT_ONE && req.char_in == CH_DOT) ? DOT_TWO : DOT_OTHER;
          end
          seg_begin_next = sb_b;
          if (sl_inc > SEG_W'(max_name)) begin
            status_next  = ST_INVALID;
            out_len_next = sb_b;
            seg_len_next = '0;
            dot_pat_next = DOT_NONE;
          end else begin
            seg_len_next = sl_inc;
            dot_pat_next = dp_b;
            out_len_next = ol_b;
            if (ol_b < LEN_W'(PATH_MAX - 1)) begin
              buf_we       = 1'b1;
              buf_waddr    = ol_b[BUF_AW-1:0];
              buf_wdata    = req.char_in;
              out_len_next = ol_b + LEN_W'(1);
            end
          end
        end
      end
    end

    // Close the current segment: drop, pop, keep or fail for lack of space
    if (do_end && seg_len != '0 && status == ST_OK) begin
      seg_len_next = '0;
      dot_pat_next = DOT_NONE;
      case (dot_pat)
        DOT_ONE: begin
          out_len_next = seg_begin;
        end
        DOT_TWO: begin
          out_len_next = seg_begin;
          if (depth != '0) begin
            depth_next   = depth - DEPTH_W'(1);
            out_len_next = stk_top;
          end
        end
        default: begin
          if (need >= NEED_W'(PATH_MAX)) begin
            status_next  = ST_NOSPACE;
            out_len_next = seg_begin;
          end else begin
            if (depth < DEPTH_W'(MAX_SEGMENTS)) begin
              stk_we     = 1'b1;
              depth_next = depth + DEPTH_W'(1);
            end
            // Lay down the separator for the next segment
            if (out_len < LEN_W'(PATH_MAX - 1)) begin
              buf_we = 1'b1;
            end
          end
        end
      endcase
    end
  end

  // Advance state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      max_name  <= NAME_LEN_RESET;
      depth     <= '0;
      out_len   <= '0;
      seg_len   <= '0;
      seg_begin <= '0;
      dot_pat   <= DOT_NONE;
      in_path   <= 1'b0;
      status    <= ST_OK;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        max_name <= cfg_write_data;
      end
      depth     <= depth_next;
      out_len   <= out_len_next;
      seg_len   <= seg_len_next;
      seg_begin <= seg_begin_next;
      dot_pat   <= dot_pat_next;
      in_path   <= in_path_next;
      status    <= status_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Capture the result item
  always_ff @(posedge clk) begin
    if (accept) begin
      done_q   <= done_next;
      status_q <= status_next;
      len_q    <= out_len_next[7:0];
      hit_q    <= read_hit;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.done_res    = done_q;
  assign rsp.status      = status_q;
  assign rsp.path_length = len_q;
  assign rsp.byte_out    = hit_q ? buf_rdata : 8'h00;

endmodule

// ===== hw/rtl/pn_ram.sv =====
// ----------------------------------------------------------------------------
// pn_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module pn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== verif/path_normalizer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// path_normalizer_tb: self-checking bench for the path normaliser
// Feeds absolute paths byte by byte, mixed with buffer reads, through
// handshakes that idle and stall at random. Each result is checked against
// a predictor of the canonical buffer that the bench keeps in step with the
// accepted request items. A short directed table comes first; random phases
// under several name length limits follow.
// ----------------------------------------------------------------------------
module path_normalizer_tb;
  import pn_pkg::*;

  typedef struct packed {
    logic    done;
    status_t status;
    byte_t   length;
    byte_t   data;
  } norm_result_t;

  typedef struct {
    cmd_t         cmd;
    byte_t        ch;
    byte_t        idx;
    bit           typed;
    norm_result_t want;
  } dir_row_t;

  typedef enum logic [1:0] {SEG_NONE, SEG_DOT, SEG_DOTDOT, SEG_NAME} seg_kind_t;

  logic  clk;
  logic  rst;
  logic  cfg_write_en;
  byte_t cfg_write_data;

  pn_in_if  req ();
  pn_out_if rsp ();

  path_normalizer u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .req            (req),
    .rsp            (rsp)
  );

  // Canonical path state mirrored by the bench
  byte_t               norm_buf [PATH_MAX];
  logic [LEN_W-1:0]    seg_starts [MAX_SEGMENTS];
  logic [DEPTH_W-1:0]  seg_depth;
  logic [LEN_W-1:0]    norm_len;
  logic [SEG_W-1:0]    seg_len;
  logic [LEN_W-1:0]    seg_base;
  seg_kind_t           seg_kind;
  logic                in_path;
  status_t             cur_status;
  byte_t               name_limit;

  norm_result_t result_q [$];
  int           errors = 0;
  int           n_sent = 0;

  // Handshake pacing
  bit           tx_idle = 1'b1;
  bit           rx_idle = 1'b1;
  bit           rsp_taken = 1'b0;
  int           stall_left = 0;
  bit           drv_typed;
  norm_result_t drv_want;

  // Clock, 10 ns period
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------- predictor
  function automatic void append_byte(input byte_t b);
    if (norm_len < PATH_MAX - 1) begin
      norm_buf[norm_len[BUF_AW-1:0]] = b;
      norm_len++;
    end
  endfunction

  function automatic void latch_error(input status_t code);
    cur_status = code;
    norm_len   = seg_base;
    seg_len    = '0;
    seg_kind   = SEG_NONE;
  endfunction

  // Decide the fate of the segment just ended
  function automatic void close_segment();
    int need;
    if (seg_len == 0 || cur_status != ST_OK) return;
    case (seg_kind)
      SEG_DOT: begin
        norm_len = seg_base;
      end
      SEG_DOTDOT: begin
        norm_len = seg_base;
        if (seg_depth > 0 && seg_depth <= MAX_SEGMENTS) begin
          seg_depth--;
          norm_len = seg_starts[seg_depth[STK_AW-1:0]];
        end
      end
      default: begin
        need = int'(seg_base) + ((seg_base > 1) ? 1 : 0) + int'(seg_len);
        if (need >= PATH_MAX) begin
          latch_error(ST_NOSPACE);
          return;
        end
        if (seg_depth < MAX_SEGMENTS) begin
          seg_starts[seg_depth[STK_AW-1:0]] = seg_base;
          seg_depth++;
        end
      end
    endcase
    seg_len  = '0;
    seg_kind = SEG_NONE;
  endfunction

  function automatic norm_result_t apply_item(input cmd_t cmd, input byte_t ch,
                                              input byte_t idx);
    norm_result_t r;
    r = '0;
    if (cmd == CMD_READ) begin
      if (idx < norm_len) r.data = norm_buf[idx];
    end else if (!in_path) begin
      // first byte of a path: start afresh
      cur_status = ST_OK;
      seg_depth  = '0;
      seg_len    = '0;
      seg_base   = '0;
      seg_kind   = SEG_NONE;
      norm_len   = '0;
      if (ch == CH_NUL) begin
        norm_buf[0] = CH_SLASH;
        norm_len    = LEN_W'(1);
        r.done      = 1'b1;
      end else if (ch == CH_SLASH) begin
        norm_buf[0] = CH_SLASH;
        norm_len    = LEN_W'(1);
        in_path     = 1'b1;
      end else begin
        cur_status = ST_INVALID;
        in_path    = 1'b1;
      end
    end else if (ch == CH_NUL) begin
      close_segment();
      seg_len  = '0;
      seg_kind = SEG_NONE;
      in_path  = 1'b0;
      r.done   = 1'b1;
    end else if (cur_status == ST_OK) begin
      if (ch == CH_SLASH) begin
        close_segment();
      end else begin
        // segment byte: open the segment with a separator where one is due
        if (seg_len == 0) begin
          seg_base = norm_len;
          if (norm_len > 1) append_byte(CH_SLASH);
          seg_kind = (ch == CH_DOT) ? SEG_DOT : SEG_NAME;
        end else if (seg_kind == SEG_DOT && ch == CH_DOT) begin
          seg_kind = SEG_DOTDOT;
        end else begin
          seg_kind = SEG_NAME;
        end
        seg_len++;
        if (seg_len > name_limit) latch_error(ST_INVALID);
        else append_byte(ch);
      end
    end
    r.status = cur_status;
    r.length = norm_len[7:0];
    return r;
  endfunction

  // ------------------------------------------------------------------ checking
  task automatic check_field(input string what, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
      errors++;
    end
  endtask

  // Predict on each accepted request, compare each accepted result
  always @(posedge clk) begin : monitor
    norm_result_t pred;
    norm_result_t want;
    if (rst) begin
      seg_depth  = '0;
      norm_len   = '0;
      seg_len    = '0;
      seg_base   = '0;
      seg_kind   = SEG_NONE;
      in_path    = 1'b0;
      cur_status = ST_OK;
      name_limit = NAME_LEN_RESET;
    end else begin
      if (cfg_write_en) name_limit = cfg_write_data;
      if (req.valid && req.ready) begin
        pred = apply_item(req.command, req.char_in, req.read_index);
        result_q.push_back(drv_typed ? drv_want : pred);
      end
      if (rsp.valid && rsp.ready) begin
        if (result_q.size() == 0) begin
          $display("%0t ns: result with none expected, got done %0d status %0d len %0d",
                   $time, rsp.done_res, rsp.status, rsp.path_length);
          errors++;
        end else begin
          want = result_q.pop_front();
          check_field("done_res", 8'(want.done), 8'(rsp.done_res));
          check_field("status", 8'(want.status), 8'(rsp.status));
          check_field("path_length", want.length, rsp.path_length);
          check_field("byte_out", want.data, rsp.byte_out);
        end
      end
    end
    rsp_taken <= rsp.valid && rsp.ready;
  end

  // Result side: hold ready low for a random count after each result
  always @(negedge clk) begin
    if (rsp_taken) stall_left = rx_idle ? $urandom_range(0, 9) : 0;
    if (stall_left > 0) begin
      rsp.ready <= 1'b0;
      stall_left--;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // ------------------------------------------------------------------ stimulus
  // Entered and left at a falling edge; valid stays high on exit so that a
  // back-to-back item follows without a bubble
  task automatic push_req(input cmd_t cmd, input byte_t ch, input byte_t idx,
                          input bit typed, input norm_result_t want);
    int gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid      <= 1'b1;
    req.command    <= cmd;
    req.char_in    <= ch;
    req.read_index <= idx;
    drv_typed      <= typed;
    drv_want       <= want;
    n_sent++;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (result_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_limit(input byte_t v);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(negedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  // Read an index up to the current path length, or anywhere
  task automatic send_read();
    byte_t idx;
    if ($urandom_range(0, 1) == 0) idx = byte_t'($urandom_range(0, 255));
    else idx = byte_t'($urandom_range(0, int'(norm_len)));
    push_req(CMD_READ, byte_t'($urandom_range(0, 255)), idx, 1'b0, '0);
  endtask

  task automatic feed_byte(input byte_t ch);
    if ($urandom_range(0, 7) == 0) send_read();
    push_req(CMD_FEED, ch, byte_t'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  function automatic byte_t name_char();
    int    r;
    byte_t c;
    r = $urandom_range(0, 9);
    if (r < 6) return byte_t'(8'h61 + $urandom_range(0, 25));
    if (r < 8) return CH_DOT;
    c = byte_t'($urandom_range(1, 255));
    return (c == CH_SLASH) ? byte_t'(8'h5F) : c;
  endfunction

  // One path: mostly well formed with random segments, sometimes noise
  task automatic send_path(input int len_cap, input int seg_cnt);
    int mode;
    int n;
    int k;
    mode = $urandom_range(0, 19);
    if (mode == 0) begin
      feed_byte(CH_NUL);
      return;
    end
    if (mode <= 2) begin
      // broken start or raw bytes, NUL included anywhere
      feed_byte(mode == 1 ? byte_t'($urandom_range(CH_SLASH + 1, 255)) : CH_SLASH);
      repeat ($urandom_range(0, 30)) feed_byte(byte_t'($urandom_range(0, 255)));
      feed_byte(CH_NUL);
      return;
    end
    feed_byte(CH_SLASH);
    for (int s = 0; s < seg_cnt; s++) begin
      if (s > 0 || $urandom_range(0, 7) == 0)
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1) feed_byte(CH_SLASH);
      k = $urandom_range(0, 5);
      if (k == 0) begin
        feed_byte(CH_DOT);
      end else if (k == 1) begin
        feed_byte(CH_DOT);
        feed_byte(CH_DOT);
      end else begin
        n = $urandom_range(1, len_cap);
        if ($urandom_range(0, 19) == 0 && name_limit < 64) n = name_limit + 1;
        repeat (n) feed_byte(name_char());
      end
    end
    if ($urandom_range(0, 3) == 0) feed_byte(CH_SLASH);
    feed_byte(CH_NUL);
  endtask

  function automatic dir_row_t run_row(input cmd_t cmd, input byte_t ch, input byte_t idx);
    dir_row_t r;
    r.cmd   = cmd;
    r.ch    = ch;
    r.idx   = idx;
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic dir_row_t chk_row(input cmd_t cmd, input byte_t ch, input byte_t idx,
                                       input logic done, input status_t st,
                                       input byte_t len, input byte_t data);
    dir_row_t r;
    r             = run_row(cmd, ch, idx);
    r.typed       = 1'b1;
    r.want.done   = done;
    r.want.status = st;
    r.want.length = len;
    r.want.data   = data;
    return r;
  endfunction

  initial begin : stim
    dir_row_t dir_rows [$];
    int       limits [8];
    int       stop_at;

    limits         = '{255, 1, 2, 3, 0, 16, 255, 200};
    rst            = 1'b1;
    cfg_write_en   = 1'b0;
    cfg_write_data = '0;
    req.valid      = 1'b0;
    req.command    = CMD_FEED;
    req.char_in    = CH_NUL;
    req.read_index = '0;
    rsp.ready      = 1'b0;
    drv_typed      = 1'b0;
    drv_want       = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table: reset state, empty path, bad first byte, dot segments
    dir_rows.push_back(chk_row(CMD_READ, CH_NUL, 8'd0,   1'b0, ST_OK, 8'd0, 8'd0));
    dir_rows.push_back(chk_row(CMD_READ, 8'hFF,  8'd255, 1'b0, ST_OK, 8'd0, 8'd0));
    dir_rows.push_back(chk_row(CMD_FEED, CH_NUL, 8'd0,   1'b1, ST_OK, 8'd1, 8'd0));
    dir_rows.push_back(chk_row(CMD_READ, CH_NUL, 8'd0,   1'b0, ST_OK, 8'd1, CH_SLASH));
    dir_rows.push_back(chk_row(CMD_FEED, 8'h61,  8'd0,   1'b0, ST_INVALID, 8'd0, 8'd0));
    dir_rows.push_back(chk_row(CMD_FEED, 8'hFF,  8'd255, 1'b0, ST_INVALID, 8'd0, 8'd0));
    dir_rows.push_back(chk_row(CMD_FEED, CH_SLASH, 8'd0, 1'b0, ST_INVALID, 8'd0, 8'd0));
    dir_rows.push_back(chk_row(CMD_FEED, CH_NUL, 8'd0,   1'b1, ST_INVALID, 8'd0, 8'd0));
    dir_rows.push_back(chk_row(CMD_FEED, CH_SLASH, 8'd0, 1'b0, ST_OK, 8'd1, 8'd0));
    dir_rows.push_back(chk_row(CMD_FEED, CH_SLASH, 8'd0, 1'b0, ST_OK, 8'd1, 8'd0));
    // ".." at the root
    dir_rows.push_back(run_row(CMD_FEED, CH_DOT,   8'd0));
    dir_rows.push_back(run_row(CMD_FEED, CH_DOT,   8'd0));
    dir_rows.push_back(run_row(CMD_FEED, CH_SLASH, 8'd0));
    // kept name with a high byte, then a dropped "."
    dir_rows.push_back(run_row(CMD_FEED, 8'h61,    8'd0));
    dir_rows.push_back(run_row(CMD_FEED, 8'h80,    8'd0));
    dir_rows.push_back(run_row(CMD_FEED, CH_SLASH, 8'd0));
    dir_rows.push_back(run_row(CMD_FEED, CH_DOT,   8'd0));
    dir_rows.push_back(run_row(CMD_FEED, CH_SLASH, 8'd0));
    // kept name popped again by ".."
    dir_rows.push_back(run_row(CMD_FEED, 8'h62,    8'd0));
    dir_rows.push_back(run_row(CMD_FEED, CH_SLASH, 8'd0));
    dir_rows.push_back(run_row(CMD_FEED, CH_DOT,   8'd0));
    dir_rows.push_back(run_row(CMD_FEED, CH_DOT,   8'd0));
    dir_rows.push_back(run_row(CMD_FEED, CH_SLASH, 8'd0));
    dir_rows.push_back(run_row(CMD_READ, CH_NUL,   8'd2));
    dir_rows.push_back(run_row(CMD_FEED, CH_NUL,   8'd0));

    foreach (dir_rows[i])
      push_req(dir_rows[i].cmd, dir_rows[i].ch, dir_rows[i].idx,
               dir_rows[i].typed, dir_rows[i].want);

    // Random phases, one name length limit each
    for (int ph = 0; ph < 8; ph++) begin
      if (ph > 0) begin
        drain();
        write_limit((limits[ph] == 0) ? byte_t'($urandom_range(4, 254)) : byte_t'(limits[ph]));
      end
      stop_at = n_sent + 90;
      // longest name within the limit, which overflows the buffer, then one that is too long
      if (ph == 6) begin
        for (int h = 255; h <= 256; h++) begin
          feed_byte(CH_SLASH);
          repeat (h) feed_byte(byte_t'(8'h61 + $urandom_range(0, 25)));
          feed_byte(CH_NUL);
        end
      end
      while (n_sent < stop_at) begin
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 3) == 0) send_path(60, $urandom_range(3, 10));
        else send_path(6, $urandom_range(0, 6));
        if ($urandom_range(0, 7) == 0) drain();
      end
    end

    drain();
    repeat (5) @(negedge clk);
    if (errors == 0) begin
      $display("path_normalizer_tb OK");
    end else begin
      $display("path_normalizer_tb NOT OK");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #5000000;
    $display("path_normalizer_tb NOT OK");
    $finish;
  end

endmodule
